@@ hdl/canonical_huffman_bit_decoder_defines.svh @@
// Assertion macros for the canonical Huffman bit decoder checker.
// Needs clk and arst_n in the scope of use.
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_DEFINES_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_DEFINES_SVH

// same-cycle implication
`define CHBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/chbd_pkg.sv @@
// Shared types and constants of the canonical Huffman bit decoder.
// No dependencies.
package chbd_pkg;

	localparam int LEN_W     = 4;
	localparam int SYM_W     = 16;
	localparam int CNT_W     = 10;
	localparam int FC_W      = 16;
	localparam int POS_W     = 15;
	localparam int LEN_SLOTS = 16;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef struct packed {
		logic load;
		logic build_start;
		logic decode;
		logic count_sweep;
		logic fc_step;
		logic place_sweep;
		logic eval;
		logic out_load;
		logic finish;
	} chbd_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic fc_done;
		logic eval_hit;
		logic eval_live;
		logic out_free;
	} chbd_sts_t;

endpackage

@@ hdl/chbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/chbd_ctrl.sv @@
// Controller state machine: load, table build sequence, decode steps.
// Depends on chbd_pkg.
module chbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              op,
	input  logic              last_entry,
	input  chbd_pkg::chbd_sts_t sts,
	output chbd_pkg::chbd_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CNT   = 3'd1;
	localparam logic [2:0] S_FC    = 3'd2;
	localparam logic [2:0] S_PLACE = 3'd3;
	localparam logic [2:0] S_EVAL  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       accept;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == chbd_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
						if (last_entry) begin
							cmd.build_start = 1'b1;
							state_d         = S_CNT;
						end
					end else begin
						cmd.decode = 1'b1;
						state_d    = S_EVAL;
					end
				end
			end
			S_CNT: begin
				cmd.count_sweep = 1'b1;
				if (sts.sweep_done) begin
					state_d = S_FC;
				end
			end
			S_FC: begin
				cmd.fc_step = 1'b1;
				if (sts.fc_done) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place_sweep = 1'b1;
				if (sts.sweep_done) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.eval_hit || !sts.eval_live) begin
					state_d = S_OUT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/chbd_datapath.sv @@
// Datapath: entry store, length counts, first codes, sorted symbols, prefix and result word.
// Depends on chbd_pkg and chbd_ram.
module chbd_datapath #(
	parameter int MAX_ENTRIES  = 512,
	parameter int MAX_CODE_LEN = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  chbd_pkg::chbd_cmd_t            cmd,
	output chbd_pkg::chbd_sts_t            sts,
	input  logic [chbd_pkg::LEN_W-1:0]     code_length,
	input  logic [chbd_pkg::SYM_W-1:0]     symbol_value,
	input  logic                           code_bit,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [chbd_pkg::SYM_W-1:0]     symbol,
	output logic                           error
);

	localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW    = $clog2(MAX_ENTRIES + 1);
	localparam int EW    = chbd_pkg::LEN_W + chbd_pkg::SYM_W;
	localparam int IDX_W = chbd_pkg::POS_W + 2;

	logic [NW-1:0] n_q, rd_idx_q;
	logic          v_s1, sweep, rd_en, ent_we;
	logic [EW-1:0] ent_rdata;
	logic [chbd_pkg::LEN_W-1:0] e_len;
	logic [chbd_pkg::SYM_W-1:0] e_sym;
	logic          e_ok;

	logic [chbd_pkg::CNT_W-1:0] cnt_q  [chbd_pkg::LEN_SLOTS];
	logic [chbd_pkg::FC_W-1:0]  fc_q   [chbd_pkg::LEN_SLOTS];
	logic [chbd_pkg::POS_W-1:0] base_q [chbd_pkg::LEN_SLOTS];
	logic [chbd_pkg::POS_W-1:0] pos_q  [chbd_pkg::LEN_SLOTS];

	logic [chbd_pkg::LEN_W-1:0] b_q, b_prev;
	logic [chbd_pkg::FC_W-1:0]  fc_sum, fc_nxt;
	logic [chbd_pkg::POS_W-1:0] base_nxt;

	logic srt_we, srt_re;
	logic [chbd_pkg::SYM_W-1:0] srt_rdata;

	logic [chbd_pkg::SYM_W-1:0] val_q, pv_q;
	logic [chbd_pkg::LEN_W:0]   d_q;
	logic [chbd_pkg::LEN_W-1:0] pd_q;
	logic                       res_err_q, oor_q;

	logic                 hit_lane  [chbd_pkg::LEN_SLOTS];
	logic                 live_lane [chbd_pkg::LEN_SLOTS];
	logic [IDX_W-1:0]     idx_lane  [chbd_pkg::LEN_SLOTS];
	logic                 eval_hit, eval_live;
	logic [IDX_W-1:0]     idx_sel;
	logic                 idx_in;

	logic                       out_valid_q, error_q;
	logic [chbd_pkg::SYM_W-1:0] symbol_q;

	// entry store and sweep address
	assign sweep  = cmd.count_sweep || cmd.place_sweep;
	assign rd_en  = sweep && (rd_idx_q < n_q);
	assign ent_we = cmd.load && (n_q < NW'(MAX_ENTRIES));
	assign e_len  = ent_rdata[EW-1:chbd_pkg::SYM_W];
	assign e_sym  = ent_rdata[chbd_pkg::SYM_W-1:0];
	assign e_ok   = (e_len != '0) && (e_len <= chbd_pkg::LEN_W'(MAX_CODE_LEN));

	chbd_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (n_q[AW-1:0]),
		.wdata ({code_length, symbol_value}),
		.re    (rd_en),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (cmd.finish) begin
				n_q <= '0;
			end else if (ent_we) begin
				n_q <= n_q + NW'(1);
			end
			if (!sweep) begin
				rd_idx_q <= '0;
				v_s1     <= 1'b0;
			end else begin
				v_s1 <= rd_en;
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + NW'(1);
				end
			end
		end
	end

	// first code and base steps, one length a cycle
	assign b_prev   = b_q - chbd_pkg::LEN_W'(1);
	assign fc_sum   = fc_q[b_prev] + chbd_pkg::FC_W'(cnt_q[b_prev]);
	assign fc_nxt   = (b_q == chbd_pkg::LEN_W'(1)) ? '0 :
		{fc_sum[chbd_pkg::FC_W-2:0], 1'b0};
	assign base_nxt = (b_q == chbd_pkg::LEN_W'(1)) ? '0 :
		base_q[b_prev] + chbd_pkg::POS_W'(cnt_q[b_prev]);

	assign srt_we = cmd.place_sweep && v_s1 && e_ok && (pos_q[e_len] < chbd_pkg::POS_W'(MAX_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= chbd_pkg::LEN_W'(1);
			for (int i = 0; i < chbd_pkg::LEN_SLOTS; i++) begin
				cnt_q[i]  <= '0;
				fc_q[i]   <= '0;
				base_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			if (cmd.build_start) begin
				for (int i = 0; i < chbd_pkg::LEN_SLOTS; i++) begin
					cnt_q[i] <= '0;
				end
			end else if (cmd.count_sweep && v_s1 && e_ok) begin
				cnt_q[e_len] <= cnt_q[e_len] + chbd_pkg::CNT_W'(1);
			end
			if (cmd.fc_step) begin
				b_q         <= b_q + chbd_pkg::LEN_W'(1);
				fc_q[b_q]   <= fc_nxt;
				base_q[b_q] <= base_nxt;
				pos_q[b_q]  <= base_nxt;
			end else begin
				b_q <= chbd_pkg::LEN_W'(1);
				if (cmd.place_sweep && v_s1 && e_ok) begin
					pos_q[e_len] <= pos_q[e_len] + chbd_pkg::POS_W'(1);
				end
			end
		end
	end

	assign sts.fc_done    = (b_q == chbd_pkg::LEN_W'(MAX_CODE_LEN));
	assign sts.sweep_done = (rd_idx_q == n_q) && !v_s1;

	// decode lanes, one per code length
	for (genvar l = 0; l < chbd_pkg::LEN_SLOTS; l++) begin : g_lane
		if (l >= 1 && l <= MAX_CODE_LEN) begin : g_on
			logic [chbd_pkg::FC_W-1:0] diff;
			logic [IDX_W-1:0]          lo, hi, hi_full;
			logic [chbd_pkg::LEN_W:0]  sh;
			assign diff    = val_q - fc_q[l];
			assign sh      = (chbd_pkg::LEN_W+1)'(l) - d_q;
			assign hi_full = IDX_W'(fc_q[l]) + IDX_W'(cnt_q[l]) - IDX_W'(1);
			assign lo      = IDX_W'(fc_q[l]) >> sh;
			assign hi      = hi_full >> sh;
			assign hit_lane[l] = (d_q == (chbd_pkg::LEN_W+1)'(l)) && (cnt_q[l] != '0) &&
				(val_q >= fc_q[l]) && (diff < chbd_pkg::FC_W'(cnt_q[l]));
			assign idx_lane[l] = IDX_W'(base_q[l]) + IDX_W'(diff);
			assign live_lane[l] = ((chbd_pkg::LEN_W+1)'(l) > d_q) && (cnt_q[l] != '0) &&
				(lo <= IDX_W'(val_q)) && (IDX_W'(val_q) <= hi);
		end else begin : g_off
			assign hit_lane[l]  = 1'b0;
			assign live_lane[l] = 1'b0;
			assign idx_lane[l]  = '0;
		end
	end

	always_comb begin
		eval_hit  = 1'b0;
		eval_live = 1'b0;
		idx_sel   = '0;
		for (int i = 0; i < chbd_pkg::LEN_SLOTS; i++) begin
			eval_hit  = eval_hit | hit_lane[i];
			eval_live = eval_live | live_lane[i];
			idx_sel   = idx_sel | (hit_lane[i] ? idx_lane[i] : '0);
		end
	end

	assign idx_in        = (idx_sel < IDX_W'(MAX_ENTRIES));
	assign srt_re        = cmd.eval && eval_hit && idx_in;
	assign sts.eval_hit  = eval_hit;
	assign sts.eval_live = eval_live;

	chbd_ram #(.WIDTH(chbd_pkg::SYM_W), .DEPTH(MAX_ENTRIES)) u_srt_ram (
		.clk   (clk),
		.we    (srt_we),
		.waddr (pos_q[e_len][AW-1:0]),
		.wdata (e_sym),
		.re    (srt_re),
		.raddr (idx_sel[AW-1:0]),
		.rdata (srt_rdata)
	);

	// prefix and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q        <= '0;
			pd_q        <= '0;
			val_q       <= '0;
			d_q         <= '0;
			res_err_q   <= 1'b0;
			oor_q       <= 1'b0;
			out_valid_q <= 1'b0;
			symbol_q    <= '0;
			error_q     <= 1'b0;
		end else begin
			if (cmd.decode) begin
				d_q   <= {1'b0, pd_q} + (chbd_pkg::LEN_W+1)'(1);
				val_q <= {pv_q[chbd_pkg::SYM_W-2:0], code_bit};
			end
			if (cmd.finish) begin
				pv_q <= '0;
				pd_q <= '0;
			end else if (cmd.eval) begin
				if (eval_hit) begin
					res_err_q <= 1'b0;
					oor_q     <= !idx_in;
					pv_q      <= '0;
					pd_q      <= '0;
				end else if (eval_live) begin
					pv_q <= val_q;
					pd_q <= d_q[chbd_pkg::LEN_W-1:0];
				end else begin
					res_err_q <= 1'b1;
					pv_q      <= '0;
					pd_q      <= '0;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				symbol_q    <= (res_err_q || oor_q) ? '0 : srt_rdata;
				error_q     <= res_err_q;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign symbol       = symbol_q;
	assign error        = error_q;

endmodule

@@ hdl/canonical_huffman_bit_decoder.sv @@
// Channel  | handshake                  | word
// item     | item_valid / item_stall    | op, code_length, symbol_value, last_entry, code_bit
// result   | result_valid / result_stall| symbol, error
//
// A load word is accepted in idle. A decode bit goes to prefix evaluation; when it ends a
// code or errors, the result register is then loaded, from a sorted-symbol RAM read on a hit.
// The last load starts a table build: a count sweep of the entry RAM read port, one
// first-code step per length, then a placement sweep of the same port.
// Reset is asynchronous; item_stall is high throughout a build or decode and while a
// result waits on result_stall for the output register.
// Top level; depends on chbd_pkg, chbd_ctrl, chbd_datapath and chbd_ram.
module canonical_huffman_bit_decoder #(
	parameter int MAX_ENTRIES  = 512,
	parameter int MAX_CODE_LEN = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        op,
	input  logic [3:0]  code_length,
	input  logic [15:0] symbol_value,
	input  logic        last_entry,
	input  logic        code_bit,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] symbol,
	output logic        error
);

	chbd_pkg::chbd_cmd_t cmd;
	chbd_pkg::chbd_sts_t sts;

	chbd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.op         (op),
		.last_entry (last_entry),
		.sts        (sts),
		.cmd        (cmd)
	);

	chbd_datapath #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.code_length  (code_length),
		.symbol_value (symbol_value),
		.code_bit     (code_bit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.symbol       (symbol),
		.error        (error)
	);

endmodule

@@ hdl/chbd_checker.sv @@
// Port-level checker for the canonical Huffman bit decoder, with its bind.
// Depends on chbd_pkg and canonical_huffman_bit_decoder_defines.svh.
`include "canonical_huffman_bit_decoder_defines.svh"

module chbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        op,
	input logic        last_entry,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] symbol,
	input logic        error
);

	`CHBD_ASSERT_NOW(a_err_sym_zero, result_valid && error, symbol == 16'd0, "error word with non-zero symbol")
	`CHBD_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(symbol) && $stable(error), "stalled result changed")
	`CHBD_ASSERT_NEXT(a_build_stall, item_valid && !item_stall && (op == chbd_pkg::OP_LOAD) && last_entry, item_stall, "build did not hold input")
	`CHBD_ASSERT_NEXT(a_load_no_res, item_valid && !item_stall && (op == chbd_pkg::OP_LOAD), !$rose(result_valid), "load gave a result")

endmodule

bind canonical_huffman_bit_decoder chbd_checker u_chbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.op           (op),
	.last_entry   (last_entry),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.symbol       (symbol),
	.error        (error)
);

@@ tb/tb_top.sv @@
// Self-checking testbench of canonical_huffman_bit_decoder: loads code length tables and
// decodes random and well-formed bit streams, checking each result word against a predictor.
// Depends on chbd_pkg and the decoder RTL.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 512;
	localparam int MAXLEN  = 15;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        op;
	logic [3:0]  code_length;
	logic [15:0] symbol_value;
	logic        last_entry;
	logic        code_bit;
	logic        result_valid;
	logic        result_stall;
	logic [15:0] symbol;
	logic        error;

	canonical_huffman_bit_decoder #(.MAX_ENTRIES(ENTRIES), .MAX_CODE_LEN(MAXLEN)) u_dut (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_stall(item_stall),
		.op(op), .code_length(code_length), .symbol_value(symbol_value),
		.last_entry(last_entry), .code_bit(code_bit), .result_valid(result_valid),
		.result_stall(result_stall), .symbol(symbol), .error(error)
	);

	typedef struct packed {
		logic        op;
		logic [3:0]  len;
		logic [15:0] sym;
		logic        last;
		logic        bit_in;
	} word_t;

	typedef struct packed {
		logic [15:0] sym;
		logic        err;
	} decoded_t;

	typedef struct {
		word_t    w;
		logic     known;
		decoded_t res;
	} row_t;

	// predictor state
	logic [3:0]  p_lens[ENTRIES];
	logic [15:0] p_syms[ENTRIES];
	logic [15:0] p_sorted[ENTRIES];
	int          p_loaded;
	logic [9:0]  p_counts[16];
	logic [15:0] p_first[16];
	logic [15:0] p_prefix;
	int          p_depth;

	decoded_t decoded_q[$];
	int       fails;
	bit       quiet;
	int       hold_off;

	// table used for well-formed streams
	int          t_len[$];
	logic [15:0] t_code[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void build_codes();
		int pos[16];
		int acc;
		int l;
		for (int b = 0; b < 16; b++) begin
			p_counts[b] = '0;
			p_first[b] = '0;
		end
		for (int i = 0; i < p_loaded; i++) begin
			l = p_lens[i];
			if (l >= 1 && l <= MAXLEN)
				p_counts[l] = p_counts[l] + 10'd1;
		end
		for (int b = 2; b <= MAXLEN; b++)
			p_first[b] = 16'((32'(p_first[b-1]) + 32'(p_counts[b-1])) << 1);
		acc = 0;
		for (int b = 0; b < 16; b++) begin
			pos[b] = acc;
			if (b >= 1)
				acc += p_counts[b];
		end
		for (int i = 0; i < p_loaded; i++) begin
			l = p_lens[i];
			if (l >= 1 && l <= MAXLEN) begin
				if (pos[l] < ENTRIES)
					p_sorted[pos[l]] = p_syms[i];
				pos[l]++;
			end
		end
		p_loaded = 0;
		p_prefix = '0;
		p_depth = 0;
	endfunction

	// returns 1 and fills res when the word yields a result
	function automatic bit decode_word(word_t w, output decoded_t res);
		int d;
		logic [15:0] v;
		longint c, lo, hi, base, idx;
		bit alive;
		res = '0;
		if (w.op == chbd_pkg::OP_LOAD) begin
			if (p_loaded < ENTRIES) begin
				p_lens[p_loaded] = w.len;
				p_syms[p_loaded] = w.sym;
				p_loaded++;
			end
			if (w.last)
				build_codes();
			return 1'b0;
		end
		d = p_depth + 1;
		v = {p_prefix[14:0], w.bit_in};
		alive = 1'b0;
		if (d <= MAXLEN) begin
			c = p_counts[d];
			if (c != 0 && v >= p_first[d] && longint'(v) - p_first[d] < c) begin
				base = 0;
				for (int l = 1; l < d; l++)
					base += p_counts[l];
				idx = base + v - p_first[d];
				res.sym = (idx < ENTRIES) ? p_sorted[idx] : 16'd0;
				res.err = 1'b0;
				p_prefix = '0;
				p_depth = 0;
				return 1'b1;
			end
			for (int l = d + 1; l <= MAXLEN; l++) begin
				c = p_counts[l];
				if (c != 0 && !alive) begin
					lo = p_first[l];
					hi = (lo + c - 1) & 64'hFFFF_FFFF;
					if ((lo >> (l - d)) <= v && v <= (hi >> (l - d)))
						alive = 1'b1;
				end
			end
		end
		if (!alive) begin
			res.err = 1'b1;
			p_prefix = '0;
			p_depth = 0;
			return 1'b1;
		end
		p_prefix = v;
		p_depth = d;
		return 1'b0;
	endfunction

	task automatic send_word(word_t w, bit gaps);
		decoded_t r;
		if (gaps && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		op <= w.op;
		code_length <= w.len;
		symbol_value <= w.sym;
		last_entry <= w.last;
		code_bit <= w.bit_in;
		do @(posedge clk); while (item_stall);
		if (decode_word(w, r))
			decoded_q.push_back(r);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// load a random, not oversubscribed table and remember its codes
	task automatic load_table(int n, int maxl, bit gaps);
		word_t w;
		int lens[$];
		int kraft;
		int need;
		int cnt[16];
		logic [15:0] fc[16];
		lens = {};
		kraft = 0;
		for (int i = 0; i < n; i++) begin
			int l;
			l = $urandom_range(0, maxl);
			if (l != 0) begin
				need = 1 << (15 - l);
				if (kraft + need > (1 << 15))
					l = 0;
				else
					kraft += need;
			end
			lens.push_back(l);
		end
		for (int b = 0; b < 16; b++) cnt[b] = 0;
		foreach (lens[i]) if (lens[i] != 0) cnt[lens[i]]++;
		fc[0] = 0;
		fc[1] = 0;
		for (int b = 2; b < 16; b++) fc[b] = 16'((fc[b-1] + cnt[b-1]) << 1);
		t_len = {};
		t_code = {};
		foreach (lens[i]) begin
			w = '0;
			w.op = chbd_pkg::OP_LOAD;
			w.len = 4'(lens[i]);
			w.sym = 16'($urandom_range(0, 65535));
			w.last = (i == n - 1);
			send_word(w, gaps);
			if (lens[i] != 0) begin
				t_len.push_back(lens[i]);
				t_code.push_back(fc[lens[i]]);
				fc[lens[i]]++;
			end
		end
	endtask

	task automatic send_bit(logic b, bit gaps);
		word_t w;
		w = '0;
		w.op = chbd_pkg::OP_DECODE;
		w.bit_in = b;
		w.len = 4'($urandom_range(0, 15));
		w.sym = 16'($urandom_range(0, 65535));
		w.last = 1'($urandom_range(0, 1));
		send_word(w, gaps);
	endtask

	// receiver stall and result check
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				result_stall <= 1'b1;
				hold_off--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(0, 3)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (decoded_q.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				decoded_t e;
				e = decoded_q.pop_front();
				if (symbol !== e.sym) begin
					$error("symbol expected %0h actual %0h", e.sym, symbol);
					fails++;
				end
				if (error !== e.err) begin
					$error("error expected %0b actual %0b", e.err, error);
					fails++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		decoded_t dummy;
		int sent;
		fails = 0;
		quiet = 1'b0;
		hold_off = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		op = 1'b0;
		code_length = '0;
		symbol_value = '0;
		last_entry = 1'b0;
		code_bit = 1'b0;
		p_loaded = 0;
		p_prefix = '0;
		p_depth = 0;
		for (int b = 0; b < 16; b++) begin
			p_counts[b] = '0;
			p_first[b] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: decode before build, extremes, length 15, unmatched prefix of ones
		rows.push_back('{'{chbd_pkg::OP_DECODE, 4'd0, 16'd0, 1'b0, 1'b1}, 1'b1,
			'{16'd0, 1'b1}});
		rows.push_back('{'{chbd_pkg::OP_LOAD, 4'd1, 16'hFFFF, 1'b0, 1'b1}, 1'b0, '0});
		rows.push_back('{'{chbd_pkg::OP_LOAD, 4'd0, 16'h1234, 1'b0, 1'b0}, 1'b0, '0});
		rows.push_back('{'{chbd_pkg::OP_LOAD, 4'd15, 16'h0000, 1'b0, 1'b0}, 1'b0, '0});
		rows.push_back('{'{chbd_pkg::OP_LOAD, 4'd2, 16'hA5A5, 1'b1, 1'b1}, 1'b0, '0});
		rows.push_back('{'{chbd_pkg::OP_DECODE, 4'hF, 16'hFFFF, 1'b1, 1'b0}, 1'b1,
			'{16'hFFFF, 1'b0}});
		rows.push_back('{'{chbd_pkg::OP_DECODE, 4'd0, 16'd0, 1'b0, 1'b1}, 1'b0, '0});
		rows.push_back('{'{chbd_pkg::OP_DECODE, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b1,
			'{16'hA5A5, 1'b0}});
		for (int i = 0; i < 14; i++)
			rows.push_back('{'{chbd_pkg::OP_DECODE, 4'd0, 16'd0, 1'b0, 1'b1}, 1'b0, '0});
		rows.push_back('{'{chbd_pkg::OP_DECODE, 4'd0, 16'd0, 1'b0, 1'b1}, 1'b1,
			'{16'd0, 1'b1}});
		foreach (rows[i]) begin
			r = rows[i];
			send_word(r.w, 1'b0);
			if (r.known && decoded_q.size() != 0) begin
				dummy = decoded_q[$];
				if (dummy !== r.res) begin
					$error("directed row %0d expected %0h predicted %0h", i, r.res, dummy);
					fails++;
				end
			end
		end
		drain();

		// fill the entry store beyond its depth, with the build on the dropped word
		for (int i = 0; i <= ENTRIES; i++) begin
			word_t w;
			w = '{chbd_pkg::OP_LOAD, 4'($urandom_range(0, 15)),
				16'($urandom_range(0, 65535)), 1'b0, 1'($urandom_range(0, 1))};
			if (i == ENTRIES)
				w.last = 1'b1;
			send_word(w, 1'b0);
		end
		for (int i = 0; i < 40; i++)
			send_bit(1'($urandom_range(0, 1)), 1'b0);
		drain();

		// random: mostly well-formed streams over legal tables
		sent = 0;
		while (sent < 1300) begin
			int n;
			bit fin;
			fin = (sent > 1050);
			quiet = fin;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 10);
			load_table(n, ($urandom_range(0, 3) == 0) ? 15 : 5, !fin);
			sent += n;
			if ($urandom_range(0, 3) == 0 && !fin)
				hold_off = 200;
			for (int k = 0; k < 30; k++) begin
				if (t_len.size() != 0 && $urandom_range(0, 5) != 0) begin
					int j;
					j = $urandom_range(0, t_len.size() - 1);
					for (int b = t_len[j] - 1; b >= 0; b--)
						send_bit(t_code[j][b], !fin);
					sent += t_len[j];
				end else begin
					send_bit(1'($urandom_range(0, 1)), !fin);
					sent++;
				end
			end
			if ($urandom_range(0, 2) == 0)
				drain();
		end
		drain();
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
